// File: rtl/hamming74_packet_receiver_defines.svh
// Assertion macros used by the packet receiver assembler.
`ifndef HAMMING74_PACKET_RECEIVER_DEFINES_SVH
`define HAMMING74_PACKET_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define HPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/hpr_pkg.sv
// Types and constants shared by the packet receiver modules.
package hpr_pkg;

  localparam int unsigned IndexWidth = 4;
  localparam logic [IndexWidth-1:0] LAST_INDEX = 4'd11;  // twelve codewords per packet
  localparam logic [7:0] NODE_ADDRESS_RESET = 8'h67;

  // Byte slots within a packet, taken from the upper bits of the codeword index.
  localparam logic [2:0] BYTE_ADDRESS  = 3'd0;
  localparam logic [2:0] BYTE_RED      = 3'd2;
  localparam logic [2:0] BYTE_GREEN    = 3'd3;
  localparam logic [2:0] BYTE_BLUE     = 3'd4;
  localparam logic [2:0] BYTE_CHECKSUM = 3'd5;

  // Syndromes that point at a data bit, and the bit each one flips.
  localparam logic [2:0] SYN_D1 = 3'd3;
  localparam logic [2:0] SYN_D2 = 3'd5;
  localparam logic [2:0] SYN_D3 = 3'd6;
  localparam logic [2:0] SYN_D4 = 3'd7;
  localparam logic [6:0] FLIP_D1 = 7'h04;
  localparam logic [6:0] FLIP_D2 = 7'h10;
  localparam logic [6:0] FLIP_D3 = 7'h20;
  localparam logic [6:0] FLIP_D4 = 7'h40;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_CHECKSUM_BAD = 2'd1,
    STATUS_ADDRESS_BAD  = 2'd2
  } hpr_status_e;

  typedef struct packed {
    logic [3:0] nibble;
    logic       fixed;
  } hpr_dec_t;

endpackage

// File: rtl/hpr_decoder.sv
// Hamming(7,4) syndrome, single-bit correction and nibble extraction.
module hpr_decoder
  import hpr_pkg::*;
(
  input  logic [6:0] codeword_i,
  output hpr_dec_t   dec_o
);

  logic [2:0] syn;
  logic [6:0] flip;
  logic [6:0] fixed_cw;

  assign syn[0] = codeword_i[0] ^ codeword_i[2] ^ codeword_i[4] ^ codeword_i[6];
  assign syn[1] = codeword_i[1] ^ codeword_i[2] ^ codeword_i[5] ^ codeword_i[6];
  assign syn[2] = codeword_i[3] ^ codeword_i[4] ^ codeword_i[5] ^ codeword_i[6];

  // A syndrome naming a parity bit leaves the data alone.
  always_comb begin
    case (syn)
      SYN_D1:  flip = FLIP_D1;
      SYN_D2:  flip = FLIP_D2;
      SYN_D3:  flip = FLIP_D3;
      SYN_D4:  flip = FLIP_D4;
      default: flip = '0;
    endcase
  end

  assign fixed_cw     = codeword_i ^ flip;
  assign dec_o.nibble = {fixed_cw[6], fixed_cw[5], fixed_cw[4], fixed_cw[2]};
  assign dec_o.fixed  = |syn;

endmodule

// File: rtl/hpr_assembler.sv
// Packet assembly from nibbles, checksum and address check, and result register.
`include "hamming74_packet_receiver_defines.svh"

module hpr_assembler
  import hpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  hpr_dec_t    dec_i,
  input  logic [7:0]  node_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hpr_status_e status_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [3:0]  count_o,
  output logic [7:0]  packet_o
);

  logic [IndexWidth-1:0] idx_q, idx_d;
  logic [3:0] held_q, held_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] red_q, red_d;
  logic [7:0] green_q, green_d;
  logic [7:0] blue_q, blue_d;
  logic [3:0] tally_q, tally_d;
  logic [7:0] total_q, total_d;

  logic        out_vld_q;
  hpr_status_e status_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q, out_packet_q;
  logic [3:0]  out_count_q;

  logic       last;
  logic       take;
  logic [7:0] byte_val;
  logic [3:0] tally_inc;
  hpr_status_e status_d;

  assign last      = (idx_q == LAST_INDEX);
  // Only the closing codeword needs room in the result register.
  assign item_ready_o = !(last && out_vld_q && !out_ready_i);
  assign take      = item_valid_i && item_ready_o;
  assign byte_val  = {held_q, dec_i.nibble};
  assign tally_inc = tally_q + {3'b000, dec_i.fixed};

  always_comb begin
    idx_d   = idx_q;
    held_d  = held_q;
    sum_d   = sum_q;
    addr_d  = addr_q;
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    tally_d = tally_q;
    total_d = total_q;
    if (take) begin
      tally_d = tally_inc;
      if (!idx_q[0]) begin
        held_d = dec_i.nibble;
      end else begin
        case (idx_q[3:1])
          BYTE_ADDRESS: addr_d  = byte_val;
          BYTE_RED:     red_d   = byte_val;
          BYTE_GREEN:   green_d = byte_val;
          BYTE_BLUE:    blue_d  = byte_val;
          default:      ;
        endcase
        if (idx_q[3:1] < BYTE_CHECKSUM) begin
          sum_d = sum_q + byte_val;
        end
      end
      if (last) begin
        idx_d   = '0;
        held_d  = '0;
        sum_d   = '0;
        tally_d = '0;
        total_d = total_q + 8'd1;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  // On the closing codeword the assembled byte is the received checksum.
  always_comb begin
    if (byte_val != sum_q) begin
      status_d = STATUS_CHECKSUM_BAD;
    end else if (addr_q != node_address_i) begin
      status_d = STATUS_ADDRESS_BAD;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      held_q  <= '0;
      sum_q   <= '0;
      addr_q  <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      tally_q <= '0;
      total_q <= '0;
    end else begin
      idx_q   <= idx_d;
      held_q  <= held_d;
      sum_q   <= sum_d;
      addr_q  <= addr_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      tally_q <= tally_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take && last) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last) begin
      status_q     <= status_d;
      out_red_q    <= red_q;
      out_green_q  <= green_q;
      out_blue_q   <= blue_q;
      out_count_q  <= tally_inc;
      out_packet_q <= total_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign red_o       = out_red_q;
  assign green_o     = out_green_q;
  assign blue_o      = out_blue_q;
  assign count_o     = out_count_q;
  assign packet_o    = out_packet_q;

  `HPR_ASSERT_NXT(a_wrap_emits, clk_i, rst_ni, take && last, (idx_q == '0) && out_vld_q, "closing codeword did not wrap the index and load a result")
  `HPR_ASSERT_NXT(a_idx_holds, clk_i, rst_ni, !take, $stable(idx_q), "codeword index moved without a beat")
  `HPR_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, last && out_vld_q && !out_ready_i, !take, "closing codeword taken while result register is full")

endmodule

// File: rtl/hamming74_packet_receiver.sv
// Hamming(7,4) packet receiver: input register, decoder and packet assembler.
// Throughput: one codeword beat per cycle unless the input side stalls; one result
// beat per twelve codewords. The twelfth codeword passes from the input register through
// decode and assembly into the result register, which then presents the result beat.
// The input side stalls only while the twelfth codeword waits for a full result register.
// Reset (rst_ni low, asynchronous) empties both registers, restarts framing at the
// first codeword, zeroes the packet number and sets the node address to 0x67.
module hamming74_packet_receiver
  import hpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // node_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // codeword
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red_level, [15:8] green_level, [23:16] blue_level,
  // [27:24] corrected_count, [35:28] packet_number, [39:36] zero
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // status
);

  logic [7:0] node_address_q;
  logic       in_vld_q;
  logic [6:0] cw_q;
  logic       item_ready;
  hpr_dec_t   dec;
  hpr_status_e status;
  logic [7:0] red, green, blue, packet;
  logic [3:0] count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= NODE_ADDRESS_RESET;
    end else if (cfg_valid_i) begin
      node_address_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = !in_vld_q || item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cw_q <= s_axis_tdata[6:0];
    end
  end

  hpr_decoder u_decoder (
    .codeword_i (cw_q),
    .dec_o      (dec)
  );

  hpr_assembler u_assembler (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_vld_q),
    .item_ready_o   (item_ready),
    .dec_i          (dec),
    .node_address_i (node_address_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (status),
    .red_o          (red),
    .green_o        (green),
    .blue_o         (blue),
    .count_o        (count),
    .packet_o       (packet)
  );

  assign m_axis_tdata = {4'b0000, packet, count, blue, green, red};
  assign m_axis_tuser = status;

endmodule
